/* sv/bdp_pkg.sv */
`default_nettype none

package bdp_pkg;

   // patch record phases
   typedef enum logic [1:0] {
      PH_CTRL  = 2'd0,
      PH_DIFF  = 2'd1,
      PH_EXTRA = 2'd2
   } phase_type;

   // configuration register indexes
   localparam logic CSR_SRC_SIZE = 1'b0;
   localparam logic CSR_NEW_SIZE = 1'b1;

   localparam int SIZE_W      = 17;
   localparam int POS_W       = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QCNT_W      = 3;
   localparam int QPTR_W      = 2;

   // item kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_PATCH = 1'b1;

   // result status codes
   localparam logic ST_OK      = 1'b0;
   localparam logic ST_CORRUPT = 1'b1;

   // classified beat from the front, old byte still to be added
   typedef struct packed {
      logic             status;
      logic             diff;
      logic             in_range;
      logic [7:0]       data;
      logic [POS_W-1:0] pos;
      logic             last;
   } op_type;

   // finished result beat
   typedef struct packed {
      logic             status;
      logic [7:0]       data;
      logic [POS_W-1:0] pos;
      logic             last;
   } rsp_type;

endpackage

`default_nettype wire

/* sv/bdp_ram.sv */
`default_nettype none

module bdp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

/* sv/bdp_front.sv */
`default_nettype none

module bdp_front import bdp_pkg::*; #(
   parameter int OLD_DEPTH = 65536,
   parameter int NEW_MAX   = 65536
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic                         csr_index,
   input  wire logic [SIZE_W-1:0]            csr_wdata,
   input  wire logic                         accept,
   input  wire logic                         kind,
   input  wire logic [7:0]                   data_byte,
   input  wire logic [15:0]                  load_address,
   output logic                              ram_we,
   output logic [$clog2(OLD_DEPTH)-1:0]      ram_wr_addr,
   output logic [$clog2(OLD_DEPTH)-1:0]      ram_rd_addr,
   output logic                              op_valid_ff,
   output op_type                            op_ff
);

   localparam int AW = $clog2(OLD_DEPTH);
   localparam logic [24:0] OLD_LIM = 25'(OLD_DEPTH);
   localparam logic [24:0] NEW_LIM = 25'(NEW_MAX);

   logic [SIZE_W-1:0] src_size_ff, new_size_ff;
   phase_type         phase_ff, phase_in;
   logic [2:0]        byte_ff, byte_in;
   logic [1:0]        word_ff, word_in;
   logic [55:0]       shift_ff, shift_in;
   logic              dneg_ff, dneg_in, dbig_ff, dbig_in;
   logic              eneg_ff, eneg_in, ebig_ff, ebig_in;
   logic [16:0]       dlen_ff, dlen_in, elen_ff, elen_in;
   logic [63:0]       seek_ff, seek_in;
   logic [16:0]       rem_ff, rem_in;
   logic [16:0]       npos_ff, npos_in;
   logic [63:0]       opos_ff, opos_in;
   logic              done_ff, done_in;
   logic              op_valid_in;
   op_type            op_in;

   logic [24:0]       eff_old;
   logic [16:0]       eff_new;
   logic [63:0]       word;
   logic [62:0]       mag;
   logic              neg, big;
   logic [63:0]       seek_val;
   logic [18:0]       end_pos;
   logic              corrupt;
   logic              in_range;
   logic [16:0]       npos_inc;

   // effective sizes, clipped to the storage
   assign eff_old = ({8'd0, src_size_ff} < OLD_LIM) ? {8'd0, src_size_ff} : OLD_LIM;
   assign eff_new = ({8'd0, new_size_ff} < NEW_LIM) ? new_size_ff : NEW_LIM[16:0];

   // word being completed by the current byte
   assign word     = {data_byte, shift_ff};
   assign mag      = word[62:0];
   assign neg      = word[63] & (|mag);
   assign big      = |mag[62:17];
   assign seek_val = neg ? (64'd0 - {1'b0, mag}) : {1'b0, mag};

   // record checks at the third word
   assign end_pos = {2'd0, npos_ff} + {2'd0, dlen_ff} + {2'd0, elen_ff};
   assign corrupt = dneg_ff | eneg_ff | dbig_ff | ebig_ff | (end_pos > {2'd0, eff_new});

   assign in_range = (opos_ff[63:25] == 39'd0) && (opos_ff[24:0] < eff_old);
   assign npos_inc = npos_ff + 17'd1;

   // old image memory ports
   assign ram_we      = accept && (kind == KIND_LOAD);
   assign ram_wr_addr = AW'({8'd0, load_address});
   assign ram_rd_addr = opos_ff[AW-1:0];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_size_ff <= '0;
         new_size_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SRC_SIZE: src_size_ff <= csr_wdata;
            CSR_NEW_SIZE: new_size_ff <= csr_wdata;
            default:      src_size_ff <= src_size_ff;
         endcase
      end
   end

   // record parser and classifier
   always_comb begin
      phase_in    = phase_ff;
      byte_in     = byte_ff;
      word_in     = word_ff;
      shift_in    = shift_ff;
      dneg_in     = dneg_ff;
      dbig_in     = dbig_ff;
      dlen_in     = dlen_ff;
      eneg_in     = eneg_ff;
      ebig_in     = ebig_ff;
      elen_in     = elen_ff;
      seek_in     = seek_ff;
      rem_in      = rem_ff;
      npos_in     = npos_ff;
      opos_in     = opos_ff;
      done_in     = done_ff;
      op_valid_in = 1'b0;
      op_in       = '0;
      op_in.data  = data_byte;
      op_in.pos   = npos_ff[POS_W-1:0];
      op_in.last  = (npos_inc >= eff_new);

      if (accept && (kind == KIND_PATCH) && !done_ff) begin
         unique case (phase_ff)
            PH_CTRL: begin
               if (!(word_ff == 2'd0 && byte_ff == 3'd0 && npos_ff >= eff_new)) begin
                  if (byte_ff != 3'd7) begin
                     shift_in[8*byte_ff +: 8] = data_byte;
                     byte_in = byte_ff + 3'd1;
                  end else begin
                     byte_in  = 3'd0;
                     shift_in = '0;
                     unique case (word_ff)
                        2'd0: begin
                           dneg_in = neg;
                           dbig_in = big;
                           dlen_in = mag[16:0];
                           word_in = 2'd1;
                        end
                        2'd1: begin
                           eneg_in = neg;
                           ebig_in = big;
                           elen_in = mag[16:0];
                           word_in = 2'd2;
                        end
                        default: begin
                           seek_in = seek_val;
                           word_in = 2'd0;
                           if (corrupt) begin
                              done_in      = 1'b1;
                              op_valid_in  = 1'b1;
                              op_in.status = ST_CORRUPT;
                              op_in.data   = 8'd0;
                              op_in.last   = 1'b0;
                           end else if (dlen_ff != 17'd0) begin
                              rem_in   = dlen_ff;
                              phase_in = PH_DIFF;
                           end else if (elen_ff != 17'd0) begin
                              rem_in   = elen_ff;
                              phase_in = PH_EXTRA;
                           end else begin
                              opos_in = opos_ff + seek_val;
                           end
                        end
                     endcase
                  end
               end
            end
            PH_DIFF: begin
               op_valid_in    = 1'b1;
               op_in.diff     = 1'b1;
               op_in.in_range = in_range;
               npos_in        = npos_inc;
               done_in        = op_in.last;
               rem_in         = rem_ff - 17'd1;
               opos_in        = opos_ff + 64'd1;
               if (rem_ff == 17'd1) begin
                  if (elen_ff != 17'd0) begin
                     rem_in   = elen_ff;
                     phase_in = PH_EXTRA;
                  end else begin
                     opos_in  = opos_ff + 64'd1 + seek_ff;
                     phase_in = PH_CTRL;
                  end
               end
            end
            PH_EXTRA: begin
               op_valid_in = 1'b1;
               npos_in     = npos_inc;
               done_in     = op_in.last;
               rem_in      = rem_ff - 17'd1;
               if (rem_ff == 17'd1) begin
                  opos_in  = opos_ff + seek_ff;
                  phase_in = PH_CTRL;
               end
            end
            default: phase_in = PH_CTRL;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_CTRL;
         byte_ff     <= '0;
         word_ff     <= '0;
         shift_ff    <= '0;
         dneg_ff     <= 1'b0;
         dbig_ff     <= 1'b0;
         dlen_ff     <= '0;
         eneg_ff     <= 1'b0;
         ebig_ff     <= 1'b0;
         elen_ff     <= '0;
         seek_ff     <= '0;
         rem_ff      <= '0;
         npos_ff     <= '0;
         opos_ff     <= '0;
         done_ff     <= 1'b0;
         op_valid_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         byte_ff     <= byte_in;
         word_ff     <= word_in;
         shift_ff    <= shift_in;
         dneg_ff     <= dneg_in;
         dbig_ff     <= dbig_in;
         dlen_ff     <= dlen_in;
         eneg_ff     <= eneg_in;
         ebig_ff     <= ebig_in;
         elen_ff     <= elen_in;
         seek_ff     <= seek_in;
         rem_ff      <= rem_in;
         npos_ff     <= npos_in;
         opos_ff     <= opos_in;
         done_ff     <= done_in;
         op_valid_ff <= op_valid_in;
      end
   end

   // classified beat, registered so that it meets the registered old byte read
   always_ff @(posedge clock) begin
      op_ff <= op_in;
   end

endmodule

`default_nettype wire

/* sv/bdp_back.sv */
`default_nettype none

module bdp_back import bdp_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              op_valid,
   input  wire op_type            op,
   input  wire logic [7:0]        old_byte,
   input  wire logic              rsp_ready,
   output logic                   rsp_valid,
   output rsp_type                rsp,
   output logic [QCNT_W-1:0]      level
);

   rsp_type           queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   rsp_type           result;
   logic              pop;

   // add the old byte to diff beats
   always_comb begin
      result.status = op.status;
      result.data   = (op.diff && op.in_range) ? (op.data + old_byte) : op.data;
      result.pos    = op.pos;
      result.last   = op.last;
   end

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp       = queue_ff[rd_ptr_ff];
   assign level     = count_ff;

   // result queue storage
   always_ff @(posedge clock) begin
      if (op_valid) begin
         queue_ff[wr_ptr_ff] <= result;
      end
   end

   // queue pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (op_valid) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         count_ff <= count_ff + QCNT_W'(op_valid) - QCNT_W'(pop);
      end
   end

endmodule

`default_nettype wire

/* sv/binary_delta_patch_applier.sv */
// channel   | direction | handshake            | beat
// req_      | in        | req_valid/req_ready  | load byte or patch byte
// rsp_      | out       | rsp_valid/rsp_ready  | new image byte or corrupt error
// csr_      | in        | csr_wr_en            | source size / new size write
//
// one item per cycle while req_ready is high; a result beat goes through the
// registered old image read and classified beat, then the queue write
// synchronous reset clears the size registers, the parser and the result queue, not the memory
// a four-entry result queue parts front from back; req_ready drops only
// when the queue and the beat in flight fill it
`default_nettype none

module binary_delta_patch_applier import bdp_pkg::*; #(
   parameter int OLD_DEPTH = 65536,
   parameter int NEW_MAX   = 65536
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic               csr_index,
   input  wire logic [SIZE_W-1:0]  csr_wdata,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_kind,
   input  wire logic [7:0]         req_data_byte,
   input  wire logic [15:0]        req_load_address,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_status,
   output logic [7:0]              rsp_new_byte,
   output logic [POS_W-1:0]        rsp_new_position,
   output logic                    rsp_last
);

   localparam int AW = $clog2(OLD_DEPTH);

   logic              accept;
   logic              ram_we;
   logic [AW-1:0]     ram_wr_addr, ram_rd_addr;
   logic [7:0]        ram_rd_data;
   logic              op_valid;
   op_type            op;
   rsp_type           rsp;
   logic [QCNT_W-1:0] level;

   // leave room for the beat in flight
   assign req_ready = ({1'b0, level} + {{QCNT_W{1'b0}}, op_valid}) < (QCNT_W+1)'(QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;

   bdp_ram #(
      .WIDTH (8),
      .DEPTH (OLD_DEPTH)
   ) u_old_image (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (req_data_byte),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bdp_front #(
      .OLD_DEPTH (OLD_DEPTH),
      .NEW_MAX   (NEW_MAX)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .accept       (accept),
      .kind         (req_kind),
      .data_byte    (req_data_byte),
      .load_address (req_load_address),
      .ram_we       (ram_we),
      .ram_wr_addr  (ram_wr_addr),
      .ram_rd_addr  (ram_rd_addr),
      .op_valid_ff  (op_valid),
      .op_ff        (op)
   );

   bdp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (op_valid),
      .op        (op),
      .old_byte  (ram_rd_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .level     (level)
   );

   assign rsp_status       = rsp.status;
   assign rsp_new_byte     = rsp.data;
   assign rsp_new_position = rsp.pos;
   assign rsp_last         = rsp.last;

endmodule

`default_nettype wire

/* sv/bdp_checker.sv */
`default_nettype none

module bdp_checker import bdp_pkg::*; (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire logic             rsp_status,
   input wire logic [7:0]       rsp_new_byte,
   input wire logic [POS_W-1:0] rsp_new_position,
   input wire logic             rsp_last
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_position)
         && $stable(rsp_new_byte) && $stable(rsp_status))
      else $error("stalled result beat changed");

   // nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result right after reset");

   // after the last byte or an error the stream stops
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (rsp_last || rsp_status == ST_CORRUPT) |=> !rsp_valid)
      else $error("result after end of image");

   // an error beat carries no byte and no last
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_CORRUPT |-> rsp_new_byte == 8'd0 && !rsp_last)
      else $error("malformed error beat");

endmodule

bind binary_delta_patch_applier bdp_checker u_bdp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_new_byte     (rsp_new_byte),
   .rsp_new_position (rsp_new_position),
   .rsp_last         (rsp_last)
);

`default_nettype wire
